// ===== design/rgbx_pkg.sv =====
// Shared types and palette constants for the RGB to xterm-256 index pipeline.
package rgbx_pkg;

    // Nearest cube level of one channel and the absolute distance to it (never above 47).
    typedef struct packed {
        logic [2:0] lvl;
        logic [5:0] gap;
    } t_chan_q;

    localparam int CUBE_LEVELS = 6;

    localparam logic [7:0] CUBE_LEVEL [CUBE_LEVELS] = '{
        8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
    };

    // A channel value at or above LVL_THRESH[i] is nearer to level i+1 than to level i.
    // Exact midpoints go to the upper level, which is the higher candidate.
    localparam logic [7:0] LVL_THRESH [CUBE_LEVELS-1] = '{
        8'd48, 8'd115, 8'd155, 8'd195, 8'd235
    };

    localparam logic [7:0] CUBE_R_STRIDE = 8'd36;
    localparam logic [7:0] CUBE_G_STRIDE = 8'd6;

    // Grey ramp: value GREY_FIRST + GREY_STEP*k, k = 0..GREY_LAST_K
    localparam logic [7:0] GREY_FIRST  = 8'd8;
    localparam logic [7:0] GREY_STEP   = 8'd10;
    localparam logic [4:0] GREY_LAST_K = 5'd23;

    // floor(x/10) = (x*205) >> 11 for every 8-bit x
    localparam logic [15:0] GREY_RECIP       = 16'd205;
    localparam int          GREY_RECIP_SHIFT = 11;

    localparam logic [7:0] CUBE_BASE = 8'd16;
    localparam logic [7:0] GREY_BASE = 8'd232;

    // Distance a winner has to beat; the result falls back to CUBE_BASE otherwise.
    localparam logic [9:0] START_BOUND = 10'd240;

endpackage

// ===== design/rgbx_chan_quant.sv =====
// Per-channel quantizer: nearest xterm cube level and its absolute distance.
module rgbx_chan_quant (
    input  logic [7:0]        i_x,
    output rgbx_pkg::t_chan_q o_q
);

    logic [2:0] w_lvl;
    logic [7:0] w_level;
    logic [7:0] w_diff;

    always_comb begin
        w_lvl = 3'd0;
        for (int i = 0; i < rgbx_pkg::CUBE_LEVELS - 1; i++) begin
            w_lvl = w_lvl + 3'(i_x >= rgbx_pkg::LVL_THRESH[i]);
        end
    end

    assign w_level = rgbx_pkg::CUBE_LEVEL[w_lvl];
    assign w_diff  = (i_x >= w_level) ? (i_x - w_level) : (w_level - i_x);

    assign o_q.lvl = w_lvl;
    assign o_q.gap = w_diff[5:0];

endmodule

// ===== design/rgb_to_xterm256_index_core.sv =====
// Top level: nearest xterm-256 palette index (sum of absolute differences) for one RGB pixel.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+------------------------------
//   pixel   | i_valid | o_ready | i_red, i_green, i_blue
//   index   | o_valid | i_ready | o_palette_index
//
// Four register stages; one pixel per cycle while the output is not stalled.
// Stage 1 quantizes each channel to the cube and takes the median, stage 2 picks the
// two grey entries around the median, stage 3 scores them, stage 4 chooses the winner.
// Reset clears the stage valid bits only. A stage loads when it is empty or moving on,
// so bubbles close up behind a stalled output and nothing is dropped or repeated.
module rgb_to_xterm256_index_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_palette_index
);

    function automatic logic [7:0] f_abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // stage enables
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: cube quantization, median ----------------
    rgbx_pkg::t_chan_q n_s1_q_red, n_s1_q_green, n_s1_q_blue;
    logic [7:0] w_min_rg, w_max_rg, w_min_mb, n_s1_median;

    rgbx_chan_quant u_q_red   (.i_x(i_red),   .o_q(n_s1_q_red));
    rgbx_chan_quant u_q_green (.i_x(i_green), .o_q(n_s1_q_green));
    rgbx_chan_quant u_q_blue  (.i_x(i_blue),  .o_q(n_s1_q_blue));

    assign w_min_rg    = (i_red < i_green) ? i_red : i_green;
    assign w_max_rg    = (i_red < i_green) ? i_green : i_red;
    assign w_min_mb    = (w_max_rg < i_blue) ? w_max_rg : i_blue;
    assign n_s1_median = (w_min_rg > w_min_mb) ? w_min_rg : w_min_mb;

    logic [7:0] r_s1_red, r_s1_green, r_s1_blue, r_s1_median;
    rgbx_pkg::t_chan_q r_s1_q_red, r_s1_q_green, r_s1_q_blue;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_red     <= i_red;
            r_s1_green   <= i_green;
            r_s1_blue    <= i_blue;
            r_s1_median  <= n_s1_median;
            r_s1_q_red   <= n_s1_q_red;
            r_s1_q_green <= n_s1_q_green;
            r_s1_q_blue  <= n_s1_q_blue;
        end
    end

    // ---------------- stage 2: cube index and distance, grey bracket ----------------
    // The grey distance is convex in the ramp value with its minimum at the median,
    // so only the ramp entries just below and just above the median can win.
    logic [7:0]  w_m_off;
    logic [15:0] w_prod;
    logic [4:0]  w_k_raw;
    logic [4:0]  n_s2_k_lo, n_s2_k_hi;
    logic [7:0]  n_s2_cube_idx, n_s2_cube_dist;

    assign w_m_off = (r_s1_median >= rgbx_pkg::GREY_FIRST) ?
                     (r_s1_median - rgbx_pkg::GREY_FIRST) : 8'd0;
    assign w_prod  = 16'(w_m_off) * rgbx_pkg::GREY_RECIP;
    assign w_k_raw = w_prod[rgbx_pkg::GREY_RECIP_SHIFT +: 5];

    assign n_s2_k_lo = (w_k_raw > rgbx_pkg::GREY_LAST_K) ? rgbx_pkg::GREY_LAST_K : w_k_raw;
    assign n_s2_k_hi = (n_s2_k_lo == rgbx_pkg::GREY_LAST_K) ? n_s2_k_lo : (n_s2_k_lo + 5'd1);

    assign n_s2_cube_idx  = 8'(r_s1_q_red.lvl) * rgbx_pkg::CUBE_R_STRIDE
                          + 8'(r_s1_q_green.lvl) * rgbx_pkg::CUBE_G_STRIDE
                          + 8'(r_s1_q_blue.lvl) + rgbx_pkg::CUBE_BASE;
    assign n_s2_cube_dist = 8'(r_s1_q_red.gap) + 8'(r_s1_q_green.gap)
                          + 8'(r_s1_q_blue.gap);

    logic [7:0] r_s2_red, r_s2_green, r_s2_blue, r_s2_cube_idx, r_s2_cube_dist;
    logic [4:0] r_s2_k_lo, r_s2_k_hi;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_red       <= r_s1_red;
            r_s2_green     <= r_s1_green;
            r_s2_blue      <= r_s1_blue;
            r_s2_cube_idx  <= n_s2_cube_idx;
            r_s2_cube_dist <= n_s2_cube_dist;
            r_s2_k_lo      <= n_s2_k_lo;
            r_s2_k_hi      <= n_s2_k_hi;
        end
    end

    // ---------------- stage 3: score both grey entries ----------------
    logic [7:0] w_grey_lo, w_grey_hi;
    logic [9:0] n_s3_d_lo, n_s3_d_hi;

    assign w_grey_lo = rgbx_pkg::GREY_FIRST + 8'(r_s2_k_lo) * rgbx_pkg::GREY_STEP;
    assign w_grey_hi = rgbx_pkg::GREY_FIRST + 8'(r_s2_k_hi) * rgbx_pkg::GREY_STEP;

    assign n_s3_d_lo = 10'(f_abs_diff(r_s2_red, w_grey_lo))
                     + 10'(f_abs_diff(r_s2_green, w_grey_lo))
                     + 10'(f_abs_diff(r_s2_blue, w_grey_lo));
    assign n_s3_d_hi = 10'(f_abs_diff(r_s2_red, w_grey_hi))
                     + 10'(f_abs_diff(r_s2_green, w_grey_hi))
                     + 10'(f_abs_diff(r_s2_blue, w_grey_hi));

    logic [7:0] r_s3_cube_idx, r_s3_cube_dist;
    logic [4:0] r_s3_k_lo, r_s3_k_hi;
    logic [9:0] r_s3_d_lo, r_s3_d_hi;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_cube_idx  <= r_s2_cube_idx;
            r_s3_cube_dist <= r_s2_cube_dist;
            r_s3_k_lo      <= r_s2_k_lo;
            r_s3_k_hi      <= r_s2_k_hi;
            r_s3_d_lo      <= n_s3_d_lo;
            r_s3_d_hi      <= n_s3_d_hi;
        end
    end

    // ---------------- stage 4: final choice ----------------
    // Ties go to the higher candidate: upper grey over lower grey, grey over cube.
    logic       w_hi_wins, w_grey_wins;
    logic [4:0] w_k;
    logic [9:0] w_d_grey, w_best_dist;
    logic [7:0] w_idx, n_s4_index;

    assign w_hi_wins   = (r_s3_d_hi <= r_s3_d_lo);
    assign w_k         = w_hi_wins ? r_s3_k_hi : r_s3_k_lo;
    assign w_d_grey    = w_hi_wins ? r_s3_d_hi : r_s3_d_lo;
    assign w_grey_wins = (w_d_grey <= 10'(r_s3_cube_dist));
    assign w_best_dist = w_grey_wins ? w_d_grey : 10'(r_s3_cube_dist);
    assign w_idx       = w_grey_wins ? (rgbx_pkg::GREY_BASE + 8'(w_k)) : r_s3_cube_idx;
    assign n_s4_index  = (w_best_dist < rgbx_pkg::START_BOUND) ? w_idx : rgbx_pkg::CUBE_BASE;

    logic [7:0] r_s4_index;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_s4_index <= n_s4_index;
        end
    end

    assign o_palette_index = r_s4_index;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for rgb_to_xterm256_index_core: directed table plus random pixels checked by a model.
module testbench;

    localparam int PALETTE_SIZE = 240;
    localparam int CUBE_SIZE    = 216;
    localparam int BEST_START   = 240;
    localparam int INDEX_BASE   = 16;
    localparam int ITEMS_PER_PH = 300;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int LATENCY      = 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        logic [7:0] index;
    } t_pixel_row;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] index;
    } t_index_due;

    localparam int NUM_ROWS = 20;

    // typed rows: primaries, corners, grey ends, grey-pair tie, cube-level tie
    localparam t_pixel_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, 8'd16},
        '{8'd255, 8'd255, 8'd255, 1'b1, 8'd231},
        '{8'd255, 8'd0,   8'd0,   1'b1, 8'd196},
        '{8'd0,   8'd255, 8'd0,   1'b1, 8'd46},
        '{8'd0,   8'd0,   8'd255, 1'b1, 8'd21},
        '{8'd255, 8'd255, 8'd0,   1'b1, 8'd226},
        '{8'd0,   8'd255, 8'd255, 1'b1, 8'd51},
        '{8'd255, 8'd0,   8'd255, 1'b1, 8'd201},
        '{8'd8,   8'd8,   8'd8,   1'b1, 8'd232},
        '{8'd238, 8'd238, 8'd238, 1'b1, 8'd255},
        '{8'd13,  8'd13,  8'd13,  1'b1, 8'd233},
        '{8'd115, 8'd0,   8'd0,   1'b1, 8'd88},
        '{8'd128, 8'd128, 8'd128, 1'b0, 8'd0},
        '{8'd1,   8'd2,   8'd3,   1'b0, 8'd0},
        '{8'd254, 8'd1,   8'd128, 1'b0, 8'd0},
        '{8'd47,  8'd48,  8'd49,  1'b0, 8'd0},
        '{8'd95,  8'd135, 8'd175, 1'b0, 8'd0},
        '{8'd127, 8'd0,   8'd255, 1'b0, 8'd0},
        '{8'd170, 8'd85,  8'd170, 1'b0, 8'd0},
        '{8'd200, 8'd100, 8'd50,  1'b0, 8'd0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_red = 8'd0;
    logic [7:0] i_green = 8'd0;
    logic [7:0] i_blue = 8'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_palette_index;

    logic [7:0] pending_index = 8'd0;
    t_index_due index_due_q[$];
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         fail_count = 0;

    rgb_to_xterm256_index_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_palette_index (o_palette_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int abs_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Exhaustive search, highest candidate first, strict compare so ties keep the higher one.
    function automatic logic [7:0] nearest_index(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        int level [6] = '{0, 95, 135, 175, 215, 255};
        int best;
        int best_dist;
        int cand_gap;
        int grey;
        best = 0;
        best_dist = BEST_START;
        for (int c = PALETTE_SIZE - 1; c >= 0; c--) begin
            if (c >= CUBE_SIZE) begin
                grey = c * 10 - 2152;
                cand_gap = abs_gap(r, grey) + abs_gap(g, grey) + abs_gap(b, grey);
            end else begin
                cand_gap = abs_gap(r, level[c / 36]) + abs_gap(g, level[(c / 6) % 6])
                         + abs_gap(b, level[c % 6]);
            end
            if (cand_gap < best_dist) begin
                best_dist = cand_gap;
                best = c;
            end
        end
        return 8'(best + INDEX_BASE);
    endfunction

    function automatic logic [7:0] clamp_chan(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return 8'(v);
    endfunction

    // Channel value near a cube level, a decision midpoint, or anywhere.
    function automatic logic [7:0] pick_chan(input int mode);
        int level [6] = '{0, 95, 135, 175, 215, 255};
        int midpt [5] = '{47, 115, 155, 195, 235};
        case (mode)
            0: return clamp_chan(level[$urandom_range(5)] + $urandom_range(24) - 12);
            1: return clamp_chan(midpt[$urandom_range(4)] + $urandom_range(2) - 1);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] index);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        pending_index <= index;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic push_random_pixel();
        int         mode;
        int         base;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        mode = $urandom_range(9);
        if (mode < 3) begin
            // near-grey: exercises grey pair selection and grey vs. cube ties
            base = $urandom_range(255);
            r = clamp_chan(base + $urandom_range(6) - 3);
            g = clamp_chan(base + $urandom_range(6) - 3);
            b = clamp_chan(base + $urandom_range(6) - 3);
        end else begin
            r = pick_chan(mode % 3);
            g = pick_chan($urandom_range(2));
            b = pick_chan($urandom_range(2));
        end
        push_pixel(r, g, b, nearest_index(r, g, b));
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_index_due due;
        if (i_valid && o_ready)
            index_due_q.push_back(t_index_due'{i_red, i_green, i_blue, pending_index});
        if (o_valid && i_ready) begin
            if (index_due_q.size() == 0) begin
                $display("%0t: unexpected index transfer, expected none, actual %0d",
                         $time, o_palette_index);
                fail_count++;
            end else begin
                due = index_due_q.pop_front();
                if (o_palette_index !== due.index) begin
                    $display("%0t: index mismatch for rgb (%0d,%0d,%0d): expected %0d, actual %0d",
                             $time, due.red, due.green, due.blue, due.index, o_palette_index);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int drain_cycles;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++) begin
            push_pixel(DIRECTED_ROWS[k].red, DIRECTED_ROWS[k].green, DIRECTED_ROWS[k].blue,
                       DIRECTED_ROWS[k].typed ? DIRECTED_ROWS[k].index
                       : nearest_index(DIRECTED_ROWS[k].red, DIRECTED_ROWS[k].green,
                                       DIRECTED_ROWS[k].blue));
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 12; sink_stall_pct = 12; end
            endcase
            for (int n = 0; n < ITEMS_PER_PH; n++)
                push_random_pixel();
        end
        i_valid <= 1'b0;

        drain_cycles = 0;
        while (index_due_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);
        if (index_due_q.size() != 0) begin
            $display("%0t: %0d index transfers never arrived, expected %0d, actual none",
                     $time, index_due_q.size(), index_due_q[0].index);
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
